// ----- src/kdhs_pkg.sv -----
// ============================================================================
// kdhs_pkg
// Shared types, widths and codes of the keyed deadline heap scheduler.
// ============================================================================
package kdhs_pkg;

    localparam int HEAP_CAP = 256;
    localparam int HEAP_AW  = $clog2(HEAP_CAP);
    localparam int SIZE_W   = HEAP_AW + 1;
    localparam int KEY_BITS = 12;
    localparam int TAG_BITS = KEY_BITS + 1;
    localparam int SLOT_AW  = TAG_BITS;
    localparam int DUE_W    = 48;
    localparam int ORDER_W  = 48;
    localparam int DLY_W    = 16;
    localparam int NOW_W    = 47;

    localparam logic [1:0] REQ_SCHED  = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NOCHG   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_NOTHING = 2'd3;

    localparam logic CFG_WATER = 1'b0;
    localparam logic CFG_LAVA  = 1'b1;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [KEY_BITS-1:0] cell_key;
        logic                is_lava;
        logic                cell_schedulable;
        logic [DLY_W-1:0]    min_delay;
        logic                force_req;
        logic [NOW_W-1:0]    now_tick;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic                popped_valid;
        logic [KEY_BITS-1:0] popped_key;
        logic                popped_lava;
        logic [DUE_W-1:0]    popped_due;
        logic                more_due;
        logic [8:0]          entry_count;
    } rsp_t;

    typedef struct packed {
        logic [DUE_W-1:0]    due;
        logic [ORDER_W-1:0]  order;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    // a runs ahead of b: earlier due, then earlier insertion
    function automatic logic entry_precedes(entry_t a, entry_t b);
        logic r;
        if (a.due != b.due)
        begin
            r = (a.due < b.due);
        end
        else
        begin
            r = (a.order < b.order);
        end
        return r;
    endfunction

endpackage

// ----- src/keyed_deadline_heap_scheduler.sv -----
// ============================================================================
// keyed_deadline_heap_scheduler
// Indexed binary min-heap of timed cell/fluid entries with a key-to-slot map.
// ============================================================================
// One request is worked at a time. A key lookup reads the slot map, then the
// heap, then checks the entry, and each heap level moved by a sift reads the
// heap memory, then compares and writes back. A schedule looks up both kinds
// of the cell, the other kind's cancel and then its own entry; for an
// unschedulable cell both kinds are looked up and cancelled.
// The result register frees the request side while a result waits.
// After reset the slot map is swept, one entry a cycle, while req_stall
// stays high; configuration writes are taken anytime.
// Slot map entries are never trusted alone: a hit needs the heap entry at
// that slot to carry the same tag, so a clear only has to zero the size.
module keyed_deadline_heap_scheduler
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  kdhs_pkg::req_t      req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output kdhs_pkg::rsp_t      rsp_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);
    import kdhs_pkg::*;

    typedef enum logic [14:0] {
        S_CLR  = 15'b000000000000001,
        S_IDLE = 15'b000000000000010,
        S_LK   = 15'b000000000000100,
        S_LK2  = 15'b000000000001000,
        S_LK3  = 15'b000000000010000,
        S_RM   = 15'b000000000100000,
        S_UP   = 15'b000000001000000,
        S_UPC  = 15'b000000010000000,
        S_DN   = 15'b000000100000000,
        S_DNC  = 15'b000001000000000,
        S_NEXT = 15'b000010000000000,
        S_POP2 = 15'b000100000000000,
        S_FIN  = 15'b001000000000000,
        S_FIN2 = 15'b010000000000000,
        S_SPR  = 15'b100000000000000
    } state_t;

    // memories
    entry_t               heap_mem [HEAP_CAP];
    logic [HEAP_AW-1:0]   slot_mem [2**SLOT_AW];

    entry_t               rd_a, rd_b;
    logic [HEAP_AW-1:0]   addr_a, addr_b;
    logic                 heap_we;
    logic [HEAP_AW-1:0]   heap_wa;
    entry_t               heap_wd;

    logic [HEAP_AW-1:0]   slot_rd;
    logic [SLOT_AW-1:0]   slot_ra;
    logic                 slot_we;
    logic [SLOT_AW-1:0]   slot_wa;
    logic [HEAP_AW-1:0]   slot_wd;

    // control and datapath registers
    state_t               state_reg, state_next;
    logic [SLOT_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [ORDER_W-1:0]   order_reg, order_next;
    logic [DLY_W-1:0]     water_reg, lava_reg;
    logic [1:0]           req_reg, req_next;
    logic                 sched_reg, sched_next;
    logic                 force_reg, force_next;
    logic [NOW_W-1:0]     now_reg, now_next;
    logic [DUE_W-1:0]     due_reg, due_next;
    logic [TAG_BITS-1:0]  own_reg, own_next;
    logic [TAG_BITS-1:0]  oth_reg, oth_next;
    logic [TAG_BITS-1:0]  lk_reg, lk_next;
    logic                 phase_reg, phase_next;
    logic                 changed_reg, changed_next;
    logic [1:0]           st_reg, st_next;
    logic [HEAP_AW-1:0]   hole_reg, hole_next;
    entry_t               elem_reg, elem_next;
    logic                 pv_reg, pv_next;
    logic [TAG_BITS-1:0]  ptag_reg, ptag_next;
    logic [DUE_W-1:0]     pdue_reg, pdue_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    // helpers
    logic [DLY_W-1:0]     base_dly, max_dly;
    logic [TAG_BITS-1:0]  in_tag, in_oth;
    logic                 found;
    logic [SIZE_W-1:0]    last_idx;
    logic [HEAP_AW-1:0]   parent_idx;
    logic [SIZE_W-1:0]    l_idx, r_idx;
    logic                 pick_r;
    entry_t               best;
    logic [HEAP_AW-1:0]   best_idx;
    logic [1:0]           final_st;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign cfg_ready = 1'b1;

    assign base_dly = req_data.is_lava ? lava_reg : water_reg;
    assign max_dly  = (req_data.min_delay > base_dly) ? req_data.min_delay : base_dly;
    assign in_tag   = {req_data.is_lava, req_data.cell_key};
    assign in_oth   = {~req_data.is_lava, req_data.cell_key};

    assign found      = ({1'b0, hole_reg} < size_reg) && (rd_a.tag == lk_reg);
    assign last_idx   = size_reg - SIZE_W'(1);
    assign parent_idx = (hole_reg - HEAP_AW'(1)) >> 1;
    assign l_idx      = {hole_reg, 1'b1};
    assign r_idx      = l_idx + SIZE_W'(1);
    assign pick_r     = (r_idx < size_reg) && entry_precedes(rd_b, rd_a);
    assign best       = pick_r ? rd_b : rd_a;
    assign best_idx   = pick_r ? r_idx[HEAP_AW-1:0] : l_idx[HEAP_AW-1:0];
    assign final_st   = ((req_reg == REQ_CANCEL) || ((req_reg == REQ_SCHED) && !sched_reg))
                        ? (changed_reg ? STAT_DONE : STAT_NOCHG) : st_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        size_next      = size_reg;
        order_next     = order_reg;
        req_next       = req_reg;
        sched_next     = sched_reg;
        force_next     = force_reg;
        now_next       = now_reg;
        due_next       = due_reg;
        own_next       = own_reg;
        oth_next       = oth_reg;
        lk_next        = lk_reg;
        phase_next     = phase_reg;
        changed_next   = changed_reg;
        st_next        = st_reg;
        hole_next      = hole_reg;
        elem_next      = elem_reg;
        pv_next        = pv_reg;
        ptag_next      = ptag_reg;
        pdue_next      = pdue_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        addr_a         = '0;
        addr_b         = '0;
        heap_we        = 1'b0;
        heap_wa        = hole_reg;
        heap_wd        = elem_reg;
        slot_ra        = lk_reg;
        slot_we        = 1'b0;
        slot_wa        = elem_reg.tag;
        slot_wd        = hole_reg;

        case (state_reg)
            S_CLR:
            begin
                slot_we      = 1'b1;
                slot_wa      = clr_cnt_reg;
                slot_wd      = '0;
                clr_cnt_next = clr_cnt_reg + SLOT_AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next     = req_data.req_type;
                    sched_next   = req_data.cell_schedulable;
                    force_next   = req_data.force_req;
                    now_next     = req_data.now_tick;
                    due_next     = DUE_W'(req_data.now_tick) + DUE_W'(max_dly);
                    own_next     = in_tag;
                    oth_next     = in_oth;
                    lk_next      = ((req_data.req_type == REQ_SCHED) &&
                                    req_data.cell_schedulable) ? in_oth : in_tag;
                    phase_next   = 1'b0;
                    changed_next = 1'b0;
                    st_next      = STAT_DONE;
                    pv_next      = 1'b0;
                    ptag_next    = '0;
                    pdue_next    = '0;
                    case (req_data.req_type)
                        REQ_SCHED, REQ_CANCEL:
                        begin
                            state_next = S_LK;
                        end
                        REQ_POP:
                        begin
                            addr_a     = '0;
                            state_next = S_POP2;
                        end
                        default:
                        begin
                            size_next  = '0;
                            order_next = '0;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_LK:
            begin
                slot_ra    = lk_reg;
                state_next = S_LK2;
            end
            S_LK2:
            begin
                hole_next  = slot_rd;
                addr_a     = slot_rd;
                state_next = S_LK3;
            end
            S_LK3:
            begin
                if ((req_reg == REQ_SCHED) && sched_reg && phase_reg)
                begin
                    // schedule of the key itself
                    if (found)
                    begin
                        if (!force_reg && (rd_a.due <= due_reg))
                        begin
                            st_next    = changed_reg ? STAT_DONE : STAT_NOCHG;
                            state_next = S_NEXT;
                        end
                        else
                        begin
                            elem_next  = '{due: due_reg, order: order_reg, tag: lk_reg};
                            order_next = order_reg + ORDER_W'(1);
                            st_next    = STAT_DONE;
                            state_next = S_UP;
                        end
                    end
                    else if (size_reg >= SIZE_W'(HEAP_CAP))
                    begin
                        st_next    = STAT_FULL;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        elem_next  = '{due: due_reg, order: order_reg, tag: lk_reg};
                        order_next = order_reg + ORDER_W'(1);
                        hole_next  = size_reg[HEAP_AW-1:0];
                        size_next  = size_reg + SIZE_W'(1);
                        st_next    = STAT_DONE;
                        state_next = S_UP;
                    end
                end
                else if (found)
                begin
                    // cancel: last entry fills the hole
                    changed_next = 1'b1;
                    size_next    = last_idx;
                    if (last_idx == {1'b0, hole_reg})
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        addr_a     = last_idx[HEAP_AW-1:0];
                        state_next = S_RM;
                    end
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_RM:
            begin
                elem_next  = rd_a;
                state_next = S_UP;
            end
            S_UP:
            begin
                if (hole_reg == '0)
                begin
                    state_next = S_DN;
                end
                else
                begin
                    addr_a     = parent_idx;
                    state_next = S_UPC;
                end
            end
            S_UPC:
            begin
                if (entry_precedes(elem_reg, rd_a))
                begin
                    heap_we    = 1'b1;
                    heap_wd    = rd_a;
                    slot_we    = 1'b1;
                    slot_wa    = rd_a.tag;
                    hole_next  = parent_idx;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_DN;
                end
            end
            S_DN:
            begin
                if (l_idx >= size_reg)
                begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    addr_a     = l_idx[HEAP_AW-1:0];
                    addr_b     = r_idx[HEAP_AW-1:0];
                    state_next = S_DNC;
                end
            end
            S_DNC:
            begin
                if (entry_precedes(best, elem_reg))
                begin
                    heap_we    = 1'b1;
                    heap_wd    = best;
                    slot_we    = 1'b1;
                    slot_wa    = best.tag;
                    hole_next  = best_idx;
                    state_next = S_DN;
                end
                else
                begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if ((req_reg == REQ_SCHED) && !phase_reg)
                begin
                    phase_next = 1'b1;
                    lk_next    = sched_reg ? own_reg : oth_reg;
                    state_next = S_LK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_POP2:
            begin
                if ((size_reg != '0) && (rd_a.due <= DUE_W'(now_reg)))
                begin
                    pv_next   = 1'b1;
                    ptag_next = rd_a.tag;
                    pdue_next = rd_a.due;
                    hole_next = '0;
                    size_next = last_idx;
                    if (last_idx == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        addr_a     = last_idx[HEAP_AW-1:0];
                        state_next = S_RM;
                    end
                end
                else
                begin
                    st_next    = STAT_NOTHING;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                addr_a     = '0;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                addr_a = '0;
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = final_st;
                    rsp_next.popped_valid = pv_reg;
                    rsp_next.popped_key  = ptag_reg[KEY_BITS-1:0];
                    rsp_next.popped_lava = ptag_reg[KEY_BITS];
                    rsp_next.popped_due  = pdue_reg;
                    rsp_next.more_due    = (size_reg != '0) &&
                                           (rd_a.due <= DUE_W'(now_reg));
                    rsp_next.entry_count = 9'(size_reg);
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        rd_a <= heap_mem[addr_a];
        rd_b <= heap_mem[addr_b];
    end

    // slot map: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            size_reg      <= '0;
            order_reg     <= '0;
            water_reg     <= DLY_W'(5);
            lava_reg      <= DLY_W'(30);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            size_reg      <= size_next;
            order_reg     <= order_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WATER: water_reg <= cfg_data;
                    CFG_LAVA:  lava_reg  <= cfg_data;
                    default:   water_reg <= water_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        sched_reg   <= sched_next;
        force_reg   <= force_next;
        now_reg     <= now_next;
        due_reg     <= due_next;
        own_reg     <= own_next;
        oth_reg     <= oth_next;
        lk_reg      <= lk_next;
        phase_reg   <= phase_next;
        changed_reg <= changed_next;
        st_reg      <= st_next;
        hole_reg    <= hole_next;
        elem_reg    <= elem_next;
        pv_reg      <= pv_next;
        ptag_reg    <= ptag_next;
        pdue_reg    <= pdue_next;
        rsp_reg     <= rsp_next;
    end

`ifndef SYNTHESIS
    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= SIZE_W'(HEAP_CAP))
        else $error("heap size beyond capacity");

    a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.popped_valid) |-> (rsp_data.status == STAT_DONE))
        else $error("popped entry with non-done status");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> req_stall)
        else $error("request taken during slot map sweep");

    a_full_keeps_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LK3 && state_next == S_NEXT && st_next == STAT_FULL)
        |=> (size_reg == SIZE_W'(HEAP_CAP)))
        else $error("dropped insert changed heap size");
`endif

endmodule

// ----- dv/kdhs_checker.sv -----
// ============================================================================
// kdhs_checker
// Watches the request, response and config channels of the keyed deadline
// heap scheduler, predicts every response and compares it field by field.
// ============================================================================
module kdhs_checker
    import kdhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req_data,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int SLOTS = 1 << TAG_BITS;

    // shadow heap
    logic [DUE_W-1:0]    hp_due [HEAP_CAP];
    logic [ORDER_W-1:0]  hp_ord [HEAP_CAP];
    logic [TAG_BITS-1:0] hp_tag [HEAP_CAP];
    int unsigned         slot_of [SLOTS];   // 0 = absent, else index + 1
    int unsigned         hp_size;
    logic [ORDER_W-1:0]  seq_next;
    logic [DLY_W-1:0]    dly_water;
    logic [DLY_W-1:0]    dly_lava;
    rsp_t                due_results[$];

    function automatic bit runs_ahead(int unsigned a, int unsigned b);
        bit r;
        if (hp_due[a] != hp_due[b])
        begin
            r = hp_due[a] < hp_due[b];
        end
        else
        begin
            r = hp_ord[a] < hp_ord[b];
        end
        return r;
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [DUE_W-1:0]    d;
        logic [ORDER_W-1:0]  o;
        logic [TAG_BITS-1:0] t;
        d = hp_due[a]; o = hp_ord[a]; t = hp_tag[a];
        hp_due[a] = hp_due[b]; hp_ord[a] = hp_ord[b]; hp_tag[a] = hp_tag[b];
        hp_due[b] = d; hp_ord[b] = o; hp_tag[b] = t;
        slot_of[hp_tag[a]] = a + 1;
        slot_of[hp_tag[b]] = b + 1;
    endfunction

    function automatic void climb(int unsigned i);
        int unsigned p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!runs_ahead(i, p))
            begin
                break;
            end
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void sink(int unsigned i);
        int unsigned l;
        int unsigned pick;
        forever
        begin
            l = 2 * i + 1;
            pick = l;
            if (l >= hp_size)
            begin
                return;
            end
            if (l + 1 < hp_size && runs_ahead(l + 1, l))
            begin
                pick = l + 1;
            end
            if (!runs_ahead(pick, i))
            begin
                return;
            end
            swap_slots(i, pick);
            i = pick;
        end
    endfunction

    function automatic void resettle(int unsigned i);
        if (i > 0 && runs_ahead(i, (i - 1) / 2))
        begin
            climb(i);
        end
        else
        begin
            sink(i);
        end
    endfunction

    function automatic void remove_at(int unsigned i);
        logic [TAG_BITS-1:0] gone;
        int unsigned         last;
        gone = hp_tag[i];
        last = hp_size - 1;
        if (i != last)
        begin
            swap_slots(i, last);
        end
        hp_size = last;
        slot_of[gone] = 0;
        if (i < hp_size)
        begin
            resettle(i);
        end
    endfunction

    function automatic bit drop_key(logic [TAG_BITS-1:0] tg);
        int unsigned s;
        s = slot_of[tg];
        if (s == 0 || s > hp_size)
        begin
            return 1'b0;
        end
        remove_at(s - 1);
        return 1'b1;
    endfunction

    function automatic rsp_t schedule_outcome(req_t r);
        rsp_t                o;
        logic [TAG_BITS-1:0] tg;
        logic [TAG_BITS-1:0] ot;
        logic [DLY_W-1:0]    base;
        logic [DUE_W-1:0]    due;
        bit                  a;
        bit                  b;
        int unsigned         s;
        o  = '0;
        tg = {r.is_lava, r.cell_key};
        ot = {~r.is_lava, r.cell_key};
        case (r.req_type)
            REQ_SCHED:
            begin
                if (!r.cell_schedulable)
                begin
                    a = drop_key(tg);
                    b = drop_key(ot);
                    o.status = (a || b) ? STAT_DONE : STAT_NOCHG;
                end
                else
                begin
                    a    = drop_key(ot);
                    base = r.is_lava ? dly_lava : dly_water;
                    if (r.min_delay > base)
                    begin
                        base = r.min_delay;
                    end
                    due = DUE_W'(r.now_tick) + DUE_W'(base);
                    s   = slot_of[tg];
                    if (s != 0 && s <= hp_size)
                    begin
                        // existing entry kept unless forced or pulled in
                        if (!r.force_req && hp_due[s-1] <= due)
                        begin
                            o.status = a ? STAT_DONE : STAT_NOCHG;
                        end
                        else
                        begin
                            hp_due[s-1] = due;
                            hp_ord[s-1] = seq_next;
                            seq_next    = seq_next + ORDER_W'(1);
                            resettle(s - 1);
                            o.status = STAT_DONE;
                        end
                    end
                    else if (hp_size >= HEAP_CAP)
                    begin
                        o.status = STAT_FULL;
                    end
                    else
                    begin
                        hp_due[hp_size] = due;
                        hp_ord[hp_size] = seq_next;
                        hp_tag[hp_size] = tg;
                        seq_next        = seq_next + ORDER_W'(1);
                        hp_size         = hp_size + 1;
                        slot_of[tg]     = hp_size;
                        climb(hp_size - 1);
                        o.status = STAT_DONE;
                    end
                end
            end
            REQ_CANCEL:
            begin
                o.status = drop_key(tg) ? STAT_DONE : STAT_NOCHG;
            end
            REQ_POP:
            begin
                if (hp_size > 0 && hp_due[0] <= r.now_tick)
                begin
                    o.popped_valid = 1'b1;
                    o.popped_key   = hp_tag[0][KEY_BITS-1:0];
                    o.popped_lava  = hp_tag[0][KEY_BITS];
                    o.popped_due   = hp_due[0];
                    remove_at(0);
                    o.status = STAT_DONE;
                end
                else
                begin
                    o.status = STAT_NOTHING;
                end
            end
            default:
            begin
                foreach (slot_of[k])
                begin
                    slot_of[k] = 0;
                end
                hp_size  = 0;
                seq_next = '0;
                o.status = STAT_DONE;
            end
        endcase
        o.more_due    = (hp_size > 0 && hp_due[0] <= r.now_tick);
        o.entry_count = hp_size[8:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp;
        bit   took_req;
        bit   took_rsp;
        if (!rst_n)
        begin
            foreach (slot_of[k])
            begin
                slot_of[k] = 0;
            end
            hp_size    = 0;
            seq_next   = '0;
            dly_water  = 16'd5;
            dly_lava   = 16'd30;
            due_results.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            took_req = req_valid && !req_stall;
            took_rsp = rsp_valid && !rsp_stall;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WATER)
                begin
                    dly_water = cfg_data;
                end
                else
                begin
                    dly_lava = cfg_data;
                end
            end
            if (took_req)
            begin
                due_results = {due_results, schedule_outcome(req_data)};
            end
            if (took_rsp)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("ERROR: unexpected response %p", rsp_data);
                    end
                end
                else
                begin
                    exp = due_results.pop_front();
                    if (rsp_data.status       !== exp.status       ||
                        rsp_data.popped_valid !== exp.popped_valid ||
                        rsp_data.popped_key   !== exp.popped_key   ||
                        rsp_data.popped_lava  !== exp.popped_lava  ||
                        rsp_data.popped_due   !== exp.popped_due   ||
                        rsp_data.more_due     !== exp.more_due     ||
                        rsp_data.entry_count  !== exp.entry_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("ERROR: response mismatch exp %p got %p", exp, rsp_data);
                        end
                    end
                end
            end
            pending <= pending + int'(took_req) - int'(took_rsp && pending > 0);
        end
    end

endmodule

// ----- dv/tb_keyed_deadline_heap_scheduler.sv -----
// ============================================================================
// tb_keyed_deadline_heap_scheduler
// Drives directed and random requests and delay settings into the scheduler
// with random idling on both channels; the checker predicts and compares.
// ============================================================================
module tb_keyed_deadline_heap_scheduler;
    import kdhs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req_data;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;

    // handshake between the sequence and the response stall process
    bit               hold_rsp;
    logic [NOW_W-1:0] cur_now;

    localparam logic [NOW_W-1:0] NOW_MAX = '1;

    keyed_deadline_heap_scheduler u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kdhs_checker u_chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = ~clk;
    end

    // run limit: covers the slot map sweep, ~1100 transactions plus the
    // longest gaps and stalls, several times over
    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    // Response side: mostly ready, short and occasional long stalls, quiet
    // stretches, and one long hold-off when the sequence asks for it.
    initial
    begin
        int k;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            k = $urandom_range(0, 99);
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                for (int c = 0; c < 400; c++)
                begin
                    @(posedge clk);
                end
                rsp_stall <= 1'b0;
                hold_rsp = 1'b0;
            end
            else if (k < 60)
            begin
                rsp_stall <= 1'b0;
            end
            else if (k < 88)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else if (k < 93)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                repeat ($urandom_range(50, 150)) @(posedge clk);
            end
        end
    end

    function automatic req_t mk(logic [1:0] op, logic [KEY_BITS-1:0] key, logic lava,
                                logic sch, logic [DLY_W-1:0] mind, logic frc,
                                logic [NOW_W-1:0] now);
        req_t r;
        r.req_type         = op;
        r.cell_key         = key;
        r.is_lava          = lava;
        r.cell_schedulable = sch;
        r.min_delay        = mind;
        r.force_req        = frc;
        r.now_tick         = now;
        return r;
    endfunction

    // Offer one transaction and hold it until taken. Valid stays high on
    // exit; the caller's gap lowers it or the next send keeps it up.
    task automatic send(req_t r);
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic gap();
        int k;
        int n;
        k = $urandom_range(0, 99);
        n = 0;
        if (k >= 55 && k < 90)
        begin
            n = $urandom_range(1, 3);
        end
        else if (k >= 90 && k < 97)
        begin
            n = $urandom_range(4, 10);
        end
        else if (k >= 97)
        begin
            n = $urandom_range(20, 60);
        end
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // wait until every response is in, then let the block settle
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic set_delays(logic [15:0] w, logic [15:0] l);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WATER;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LAVA;
        cfg_data  <= l;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random request: small key pool so keys collide, time marching forward
    // so pops mostly find due entries; now and then full-range values.
    task automatic random_req();
        req_t r;
        int   k;
        k = $urandom_range(0, 99);
        r.req_type = (k < 45) ? REQ_SCHED : (k < 65) ? REQ_CANCEL :
                     (k < 98) ? REQ_POP : REQ_CLEAR;
        r.cell_key = ($urandom_range(0, 9) == 0) ? KEY_BITS'($urandom) :
                     KEY_BITS'($urandom_range(0, 31));
        r.is_lava          = 1'($urandom_range(0, 1));
        r.cell_schedulable = ($urandom_range(0, 7) != 0);
        r.force_req        = ($urandom_range(0, 3) == 0);
        k = $urandom_range(0, 9);
        r.min_delay = (k < 2) ? 16'd0 : (k < 9) ? 16'($urandom_range(0, 40)) : 16'($urandom);
        cur_now = cur_now + NOW_W'($urandom_range(0, 20));
        r.now_tick = cur_now;
        if ($urandom_range(0, 29) == 0)
        begin
            r.now_tick = {15'($urandom), 32'($urandom)};
        end
        send(r);
        gap();
    endtask

    // Fill past capacity to hit the full case, move an entry while full,
    // then pop everything at a far-future tick.
    task automatic fill_and_empty();
        send(mk(REQ_CLEAR, '0, 1'b0, 1'b0, '0, 1'b0, cur_now));
        for (int i = 0; i < 270; i++)
        begin
            send(mk(REQ_SCHED, KEY_BITS'(i), 1'($urandom), 1'b1,
                    16'($urandom_range(0, 500)), 1'($urandom), cur_now));
            gap();
        end
        send(mk(REQ_SCHED, KEY_BITS'(7), 1'b0, 1'b1, 16'd0, 1'b1, cur_now));
        send(mk(REQ_SCHED, KEY_BITS'(7), 1'b1, 1'b1, 16'd0, 1'b1, cur_now));
        for (int i = 0; i < 262; i++)
        begin
            send(mk(REQ_POP, '0, 1'b0, 1'b0, '0, 1'b0, cur_now + 47'd70000));
            gap();
        end
    endtask

    initial
    begin
        logic [NOW_W-1:0] t0;
        rst_n     = 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_WATER;
        cfg_data  <= '0;
        hold_rsp  = 1'b0;
        cur_now   = 47'd1000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset delays (water 5, lava 30)
        t0 = 47'd1000;
        send(mk(REQ_POP,    '0, 1'b0, 1'b0, '0, 1'b0, t0));              // empty pop
        send(mk(REQ_CANCEL, '0, 1'b0, 1'b0, '0, 1'b0, t0));              // absent key
        send(mk(REQ_SCHED,  '0, 1'b0, 1'b1, 16'd0, 1'b0, t0));
        send(mk(REQ_SCHED,  '1, 1'b1, 1'b1, 16'hFFFF, 1'b1, t0));
        send(mk(REQ_SCHED,  '0, 1'b0, 1'b1, 16'd100, 1'b0, t0));         // kept entry
        send(mk(REQ_SCHED,  '0, 1'b0, 1'b1, 16'd100, 1'b1, t0));         // forced move
        send(mk(REQ_SCHED,  '0, 1'b0, 1'b1, 16'd1, 1'b0, t0));           // pulled in
        send(mk(REQ_SCHED,  '0, 1'b1, 1'b1, 16'd0, 1'b0, t0));           // drops water
        send(mk(REQ_SCHED,  '0, 1'b1, 1'b0, 16'd0, 1'b0, t0));           // unschedulable
        send(mk(REQ_SCHED,  '0, 1'b0, 1'b0, 16'd0, 1'b0, t0));           // nothing to drop
        send(mk(REQ_SCHED,  12'd5, 1'b0, 1'b1, 16'd0, 1'b0, t0));
        send(mk(REQ_SCHED,  12'd6, 1'b0, 1'b1, 16'd0, 1'b0, t0));        // tie on due
        send(mk(REQ_SCHED,  12'd6, 1'b1, 1'b1, 16'd0, 1'b0, t0));        // drops water
        send(mk(REQ_POP,    '0, 1'b0, 1'b0, '0, 1'b0, t0));              // not due
        send(mk(REQ_POP,    '0, 1'b0, 1'b0, '0, 1'b0, t0 + 47'd5));
        send(mk(REQ_POP,    '0, 1'b0, 1'b0, '0, 1'b0, t0 + 47'd5));
        send(mk(REQ_CANCEL, '1, 1'b1, 1'b1, '0, 1'b0, t0));
        send(mk(REQ_SCHED,  '1, 1'b0, 1'b1, 16'hFFFF, 1'b0, NOW_MAX));   // due past 47 bits
        send(mk(REQ_SCHED,  12'd9, 1'b1, 1'b1, 16'd0, 1'b0, t0));
        send(mk(REQ_POP,    '0, 1'b0, 1'b0, '0, 1'b0, NOW_MAX));
        send(mk(REQ_POP,    '0, 1'b0, 1'b0, '0, 1'b0, NOW_MAX));
        send(mk(REQ_CLEAR,  '0, 1'b0, 1'b0, '0, 1'b0, t0));
        send(mk(REQ_SCHED,  12'd3, 1'b0, 1'b1, 16'd0, 1'b0, t0));        // order restarts
        send(mk(REQ_POP,    '0, 1'b0, 1'b0, '0, 1'b0, NOW_MAX));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1: set_delays(16'd0, 16'hFFFF);
                2: set_delays(16'hFFFF, 16'd0);
                3: set_delays(16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)));
                4: set_delays(16'($urandom), 16'($urandom));
                5: set_delays(16'd3, 16'd7);
                default: ;
            endcase
            if (ph == 3)
            begin
                fill_and_empty();
            end
            if (ph == 2)
            begin
                // long receiver hold-off while requests keep coming
                hold_rsp = 1'b1;
                for (int i = 0; i < 30; i++)
                begin
                    send(mk(REQ_SCHED, KEY_BITS'($urandom_range(0, 31)), 1'($urandom),
                            1'b1, 16'($urandom_range(0, 40)), 1'b0, cur_now));
                end
            end
            for (int i = 0; i < 80; i++)
            begin
                random_req();
            end
            drain();
        end

        drain();
        if (fail_count == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/kdhs_pkg.sv
src/keyed_deadline_heap_scheduler.sv
dv/kdhs_checker.sv
dv/tb_keyed_deadline_heap_scheduler.sv
